FILE: sv/t2dp_pkg.sv
package t2dp_pkg;

    localparam int REG_COUNT = 16;
    localparam int REG_IDX_W = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] ST_EXEC    = 2'd0;
    localparam logic [1:0] ST_UNPRED  = 2'd1;
    localparam logic [1:0] ST_RESERVD = 2'd2;

    // modified-immediate opcodes
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_BIC = 4'd1;
    localparam logic [3:0] OP_ORR = 4'd2;
    localparam logic [3:0] OP_ORN = 4'd3;
    localparam logic [3:0] OP_EOR = 4'd4;
    localparam logic [3:0] OP_ADD = 4'd8;
    localparam logic [3:0] OP_ADC = 4'd10;
    localparam logic [3:0] OP_SBC = 4'd11;
    localparam logic [3:0] OP_SUB = 4'd13;
    localparam logic [3:0] OP_RSB = 4'd14;

    // plain-immediate opcodes
    localparam logic [4:0] P_ADDW = 5'd0;
    localparam logic [4:0] P_MOVW = 5'd4;
    localparam logic [4:0] P_SUBW = 5'd10;
    localparam logic [4:0] P_MOVT = 5'd12;
    localparam logic [4:0] P_SSAT = 5'd16;
    localparam logic [4:0] P_SSATA = 5'd18;
    localparam logic [4:0] P_SBFX = 5'd20;
    localparam logic [4:0] P_BFI  = 5'd22;
    localparam logic [4:0] P_USAT = 5'd24;
    localparam logic [4:0] P_USATA = 5'd26;
    localparam logic [4:0] P_UBFX = 5'd28;

    typedef struct packed {
        logic        reg_write;
        logic [3:0]  dest_reg;
        logic [31:0] result_value;
        logic        flags_write;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
        logic        flag_q;
        logic [1:0]  status;
    } result_t;

    // register-file write port
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

    function automatic logic [31:0] ones_upto(input logic [4:0] n);
        logic [32:0] t;
        t = (33'd2 << n) - 33'd1;
        return t[31:0];
    endfunction

endpackage

FILE: sv/thumb2_imm_data_processing_unit.sv
// channel | dir | tdata bits (low first)                 | tuser
// s_axis  | in  | instr_word[31:0], pc_value[63:32]      | -
// m_axis  | out | reg_write[0], dest_reg[4:1], result_value[36:5], | -
//         |     | flags_write[37], n z c v q [42:38], status[44:43], pad
// One item per cycle unless the skid buffer is full. Stage 1 reads Rn and Rd
// from the register file memory, stage 2 executes and writes back; a result in
// stage 2 forwards to a following read of the same register. Output register
// with skid buffer. Reset clears flags and Q; register entries read as zero
// until first written, via per-entry valid bits; no sweep.
module thumb2_imm_data_processing_unit
    import t2dp_pkg::*;
#(
    parameter int RegCount = REG_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // instr_word, pc_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // reg_write, dest_reg, result_value, flags_write,
                                        // n, z, c, v, q, status
);
    logic        ex_v_reg;
    logic [31:0] ex_w_reg, ex_pc_reg;
    logic        fa_reg, fb_reg;
    logic [31:0] fd_a_reg, fd_b_reg;
    logic [3:0]  nzcv_reg;
    logic        q_reg;
    logic [31:0] rf_a, rf_b, src, old_rd;
    result_t     alu_res;
    logic [3:0]  nzcv_next;
    logic        q_next;
    rf_wr_t      wr;
    logic        out_v_reg, skid_v_reg;
    result_t     out_reg, skid_reg;
    logic        adv;

    // stage 2 may move on unless both output slots are full
    assign adv           = !skid_v_reg;
    assign s_axis_tready = adv;

    assign wr.en   = ex_v_reg && adv && alu_res.reg_write;
    assign wr.addr = alu_res.dest_reg;
    assign wr.data = alu_res.result_value;

    t2dp_regfile #(.Depth(RegCount)) u_rf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (s_axis_tvalid && adv),
        .rd_addr_a (s_axis_tdata[19:16]),
        .rd_addr_b (s_axis_tdata[11:8]),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr        (wr)
    );

    assign src    = fa_reg ? fd_a_reg : rf_a;
    assign old_rd = fb_reg ? fd_b_reg : rf_b;

    t2dp_alu u_alu (
        .w        (ex_w_reg),
        .pc       (ex_pc_reg),
        .src      (src),
        .old_rd   (old_rd),
        .nzcv     (nzcv_reg),
        .q_in     (q_reg),
        .res      (alu_res),
        .nzcv_out (nzcv_next),
        .q_out    (q_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_v_reg   <= 1'b0;
            fa_reg     <= 1'b0;
            fb_reg     <= 1'b0;
            nzcv_reg   <= '0;
            q_reg      <= 1'b0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                ex_v_reg <= s_axis_tvalid;
                fa_reg   <= wr.en && wr.addr == s_axis_tdata[19:16];
                fb_reg   <= wr.en && wr.addr == s_axis_tdata[11:8];
                if (ex_v_reg)
                begin
                    nzcv_reg <= nzcv_next;
                    q_reg    <= q_next;
                end
            end
            if (!out_v_reg || m_axis_tready)
            begin
                if (skid_v_reg)
                begin
                    out_v_reg  <= 1'b1;
                    skid_v_reg <= 1'b0;
                end
                else
                    out_v_reg <= ex_v_reg;
            end
            else if (ex_v_reg && adv)
                skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_w_reg  <= s_axis_tdata[31:0];
            ex_pc_reg <= s_axis_tdata[63:32];
            fd_a_reg  <= wr.data;
            fd_b_reg  <= wr.data;
        end
        if (!out_v_reg || m_axis_tready)
            out_reg <= skid_v_reg ? skid_reg : alu_res;
        else if (ex_v_reg && adv)
            skid_reg <= alu_res;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {3'd0, out_reg.status, out_reg.flag_q, out_reg.flag_v,
                            out_reg.flag_c, out_reg.flag_z, out_reg.flag_n,
                            out_reg.flags_write, out_reg.result_value,
                            out_reg.dest_reg, out_reg.reg_write};

endmodule

FILE: sv/t2dp_regfile.sv
module t2dp_regfile
    import t2dp_pkg::*;
#(
    parameter int Depth = REG_COUNT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr_a,
    input  logic [$clog2(Depth)-1:0] rd_addr_b,
    output logic [31:0]              rd_data_a,
    output logic [31:0]              rd_data_b,
    input  rf_wr_t                   wr
);
    // two read copies of the same contents; valid bits give the reset value
    logic [31:0]      mem_a [Depth];
    logic [31:0]      mem_b [Depth];
    logic [Depth-1:0] valid_reg;
    logic             va_reg, vb_reg;
    logic [31:0]      qa_reg, qb_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_a[wr.addr[$clog2(Depth)-1:0]] <= wr.data;
            mem_b[wr.addr[$clog2(Depth)-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            qa_reg <= mem_a[rd_addr_a];
            qb_reg <= mem_b[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                va_reg <= valid_reg[rd_addr_a];
                vb_reg <= valid_reg[rd_addr_b];
            end
            if (wr.en)
                valid_reg[wr.addr[$clog2(Depth)-1:0]] <= 1'b1;
        end
    end

    assign rd_data_a = va_reg ? qa_reg : '0;
    assign rd_data_b = vb_reg ? qb_reg : '0;

endmodule

FILE: sv/t2dp_alu.sv
module t2dp_alu
    import t2dp_pkg::*;
(
    input  logic [31:0] w,
    input  logic [31:0] pc,
    input  logic [31:0] src,
    input  logic [31:0] old_rd,
    input  logic [3:0]  nzcv,
    input  logic        q_in,
    output result_t     res,
    output logic [3:0]  nzcv_out,
    output logic        q_out
);
    logic        i_bit;
    logic [3:0]  rn, rd, op;
    logic [2:0]  imm3;
    logic [7:0]  imm8;
    logic [11:0] imm12;
    logic [4:0]  op5, lsb, low5, rot;
    logic        s_bit, cin;
    logic [1:0]  status;
    logic        wr, fw, qset;
    logic [31:0] r, imm, m, ins, sh, exv;
    logic        ic, c, v;
    logic [32:0] sum;
    logic [31:0] ax, ay;
    logic        acin;
    logic [31:0] b;
    logic [5:0]  n_bits;
    logic signed [32:0] xs, hi, lo;
    logic [3:0]  nz_next;

    always_comb
    begin
        i_bit  = w[26];
        rn     = w[19:16];
        rd     = w[11:8];
        imm3   = w[14:12];
        imm8   = w[7:0];
        imm12  = {i_bit, imm3, imm8};
        op     = w[24:21];
        s_bit  = w[20];
        op5    = w[24:20];
        lsb    = {imm3, w[7:6]};
        low5   = w[4:0];
        cin    = nzcv[1];
        status = ST_RESERVD;
        wr = 1'b0; fw = 1'b0; qset = 1'b0;
        r = '0; imm = '0; ic = cin; c = 1'b0; v = 1'b0;
        m = '0; ins = '0; sh = '0; exv = '0;
        ax = '0; ay = '0; acin = 1'b0; sum = '0;
        b = {24'd0, imm8}; rot = imm12[11:7]; n_bits = '0;
        xs = '0; hi = '0; lo = '0;
        nz_next = nzcv;

        // ThumbExpandImm
        if (imm12[11:10] == 2'b00)
        begin
            case (imm12[9:8])
                2'd0: imm = b;
                2'd1: imm = {8'd0, imm8, 8'd0, imm8};
                2'd2: imm = {imm8, 8'd0, imm8, 8'd0};
                default: imm = {imm8, imm8, imm8, imm8};
            endcase
            ic = cin;
        end
        else
        begin
            exv = {24'd0, 1'b1, imm12[6:0]};
            imm = (exv >> rot) | (exv << (6'd32 - {1'b0, rot}));
            ic  = imm[31];
        end

        if (w[31:27] == 5'b11110 && !w[15])
        begin
            if (!w[25])
            begin
                if (op inside {OP_AND, OP_BIC, OP_ORR, OP_ORN, OP_EOR,
                               OP_ADD, OP_ADC, OP_SBC, OP_SUB, OP_RSB})
                begin
                    if (imm12[11:10] == 2'b00 && imm12[9:8] != 2'b00 && imm8 == 8'd0)
                        status = ST_UNPRED;
                    else
                    begin
                        status = ST_EXEC;
                        case (op)
                            OP_ADD: begin ax = src;  ay = imm;  acin = 1'b0; end
                            OP_ADC: begin ax = src;  ay = imm;  acin = cin;  end
                            OP_SBC: begin ax = src;  ay = ~imm; acin = cin;  end
                            OP_SUB: begin ax = src;  ay = ~imm; acin = 1'b1; end
                            default: begin ax = ~src; ay = imm; acin = 1'b1; end
                        endcase
                        sum = {1'b0, ax} + {1'b0, ay} + {32'd0, acin};
                        c = sum[32];
                        v = (~(ax[31] ^ ay[31])) & (ax[31] ^ sum[31]);
                        case (op)
                            OP_AND: r = src & imm;
                            OP_BIC: r = src & ~imm;
                            OP_ORR: r = (rn == 4'hf) ? imm : (src | imm);
                            OP_ORN: r = (rn == 4'hf) ? ~imm : (src | ~imm);
                            OP_EOR: r = src ^ imm;
                            default: r = sum[31:0];
                        endcase
                        if (s_bit)
                        begin
                            fw = 1'b1;
                            if (op <= OP_EOR)
                                nz_next = {r[31], r == 32'd0, ic, nzcv[0]};
                            else
                                nz_next = {r[31], r == 32'd0, c, v};
                        end
                        wr = !(s_bit && rd == 4'hf &&
                               (op == OP_AND || op == OP_EOR || op == OP_ADD || op == OP_SUB));
                    end
                end
            end
            else
            begin
                case (op5)
                    P_ADDW, P_SUBW:
                    begin
                        ax = (rn == 4'hf) ? {pc[31:2], 2'b00} : src;
                        r  = (op5 == P_ADDW) ? ax + {20'd0, imm12} : ax - {20'd0, imm12};
                        status = ST_EXEC; wr = 1'b1;
                    end
                    P_MOVW:
                    begin
                        r = {16'd0, rn, imm12};
                        status = ST_EXEC; wr = 1'b1;
                    end
                    P_MOVT:
                    begin
                        r = {rn, imm12, old_rd[15:0]};
                        status = ST_EXEC; wr = 1'b1;
                    end
                    P_SSAT, P_SSATA, P_USAT, P_USATA:
                    begin
                        if (i_bit || w[5] || (op5[1] && lsb == 5'd0))
                            status = ST_UNPRED;
                        else
                        begin
                            sh = op5[1] ? 32'($signed(src) >>> lsb) : (src << lsb);
                            xs = 33'($signed(sh));
                            if (op5 < P_USAT)
                            begin
                                hi = (33'sd1 <<< low5) - 33'sd1;
                                lo = -(33'sd1 <<< low5);
                            end
                            else
                            begin
                                hi = (33'sd1 <<< low5) - 33'sd1;
                                lo = '0;
                            end
                            if (xs > hi)      begin xs = hi; qset = 1'b1; end
                            else if (xs < lo) begin xs = lo; qset = 1'b1; end
                            r = xs[31:0];
                            status = ST_EXEC; wr = 1'b1;
                        end
                    end
                    P_BFI:
                    begin
                        if (i_bit || w[5] || low5 < lsb)
                            status = ST_UNPRED;
                        else
                        begin
                            m   = ones_upto(low5) & ~(ones_upto(lsb) >> 1);
                            ins = (rn == 4'hf) ? 32'd0 : (src << lsb);
                            r   = (old_rd & ~m) | (ins & m);
                            status = ST_EXEC; wr = 1'b1;
                        end
                    end
                    P_SBFX, P_UBFX:
                    begin
                        n_bits = {1'b0, lsb} + {1'b0, low5};
                        if (i_bit || w[5] || n_bits > 6'd31)
                            status = ST_UNPRED;
                        else
                        begin
                            r = (src >> lsb) & ones_upto(low5);
                            if (op5 == P_SBFX && r[low5])
                                r = r | ~ones_upto(low5);
                            status = ST_EXEC; wr = 1'b1;
                        end
                    end
                    default: status = ST_RESERVD;
                endcase
            end
        end

        if (status != ST_EXEC)
        begin
            r = '0; wr = 1'b0; fw = 1'b0; qset = 1'b0; nz_next = nzcv;
        end
        nzcv_out = nz_next;
        q_out    = q_in | qset;
        res.reg_write    = wr;
        res.dest_reg     = (status == ST_EXEC) ? rd : 4'd0;
        res.result_value = r;
        res.flags_write  = fw;
        res.flag_n       = nz_next[3];
        res.flag_z       = nz_next[2];
        res.flag_c       = nz_next[1];
        res.flag_v       = nz_next[0];
        res.flag_q       = q_out;
        res.status       = status;
    end

endmodule

FILE: sv/t2dp_checker.sv
module t2dp_checker
    import t2dp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    // status must be a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[44:43] != 2'd3)
        else $error("bad status");

    // nothing written or flagged unless executed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[44:43] != ST_EXEC |->
            !m_axis_tdata[0] && !m_axis_tdata[37] && m_axis_tdata[36:5] == 32'd0)
        else $error("side effect on skipped item");

    // Q is sticky between consecutive results
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[42] |=>
            !m_axis_tvalid || m_axis_tdata[42])
        else $error("Q cleared");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");

    // an offered item is taken while the output side is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind thumb2_imm_data_processing_unit t2dp_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/tb_thumb2_imm_data_processing_unit.sv
`timescale 1ns / 1ps

module tb_thumb2_imm_data_processing_unit;
    import t2dp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // instr_word, pc_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // reg_write, dest_reg, result_value, flags_write,
                                 // n, z, c, v, q, status

    thumb2_imm_data_processing_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic [31:0] regs [16];
    logic [3:0]  nzcv;
    logic        qflag;

    logic [63:0] pending_items [$];
    result_t     expected_results [$];
    int          mismatches;
    int          cycles;
    bit          stim_done;
    bit          hold_send;
    bit          quiet;
    bit          in_taken;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] mask_upto(input logic [4:0] n);
        logic [32:0] t;
        t = (33'd2 << n) - 33'd1;
        return t[31:0];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
        return (v >> n) | (v << (6'd32 - {1'b0, n}));
    endfunction

    // executes one instruction on the predictor state
    function automatic result_t execute_instr(input logic [31:0] w, input logic [31:0] pc);
        result_t     r;
        logic [1:0]  st;
        logic        wr, fw, i, s, cin, ic, logic_op, arith, ok, asr;
        logic [3:0]  rn, rd, op;
        logic [2:0]  imm3;
        logic [7:0]  b;
        logic [11:0] imm12;
        logic [31:0] src, res, imm, m, ins, sh, bse, v;
        logic [32:0] sum;
        logic [4:0]  op5, lsb, low5;
        logic [15:0] imm16;
        longint      x, hi, lo;
        st = ST_RESERVD; wr = 1'b0; fw = 1'b0; res = '0;
        i = w[26]; rn = w[19:16]; rd = w[11:8]; imm3 = w[14:12];
        imm12 = {i, imm3, w[7:0]};
        src = regs[rn]; cin = nzcv[1];
        if (w[31:27] == 5'b11110 && !w[15])
        begin
            if (!w[25])
            begin
                op = w[24:21]; s = w[20];
                logic_op = op <= OP_EOR;
                arith = op inside {OP_ADD, OP_ADC, OP_SBC, OP_SUB, OP_RSB};
                if (logic_op || arith)
                begin
                    b = imm12[7:0]; ok = 1'b1; ic = cin; imm = '0;
                    if (imm12[11:10] == 2'b00)
                    begin
                        case (imm12[9:8])
                            2'd0: imm = {24'd0, b};
                            2'd1: imm = {8'd0, b, 8'd0, b};
                            2'd2: imm = {b, 8'd0, b, 8'd0};
                            default: imm = {b, b, b, b};
                        endcase
                        if (imm12[9:8] != 2'd0 && b == 8'd0) ok = 1'b0;
                    end
                    else
                    begin
                        imm = rotr({24'd0, 1'b1, imm12[6:0]}, imm12[11:7]);
                        ic = imm[31];
                    end
                    if (!ok)
                        st = ST_UNPRED;
                    else
                    begin
                        st = ST_EXEC;
                        if (logic_op)
                        begin
                            case (op)
                                OP_AND: res = src & imm;
                                OP_BIC: res = src & ~imm;
                                OP_ORR: res = (rn == 4'hf) ? imm : (src | imm);
                                OP_ORN: res = (rn == 4'hf) ? ~imm : (src | ~imm);
                                default: res = src ^ imm;
                            endcase
                            if (s)
                            begin
                                nzcv = {res[31], res == 32'd0, ic, nzcv[0]};
                                fw = 1'b1;
                            end
                        end
                        else
                        begin
                            case (op)
                                OP_ADD: sum = {1'b0, src} + {1'b0, imm};
                                OP_ADC: sum = {1'b0, src} + {1'b0, imm} + {32'd0, cin};
                                OP_SBC: sum = {1'b0, src} + {1'b0, ~imm} + {32'd0, cin};
                                OP_SUB: sum = {1'b0, src} + {1'b0, ~imm} + 33'd1;
                                default: sum = {1'b0, ~src} + {1'b0, imm} + 33'd1;
                            endcase
                            res = sum[31:0];
                            if (s)
                            begin
                                if (op == OP_SBC || op == OP_SUB)
                                    v = ~(src ^ ~imm) & (src ^ res);
                                else if (op == OP_RSB)
                                    v = ~(~src ^ imm) & (~src ^ res);
                                else
                                    v = ~(src ^ imm) & (src ^ res);
                                nzcv = {res[31], res == 32'd0, sum[32], v[31]};
                                fw = 1'b1;
                            end
                        end
                        // compare forms discard the result
                        wr = !(s && rd == 4'hf && op inside {OP_AND, OP_EOR, OP_ADD, OP_SUB});
                    end
                end
            end
            else
            begin
                op5 = w[24:20];
                lsb = {imm3, w[7:6]};
                low5 = w[4:0];
                if (op5 == P_ADDW || op5 == P_SUBW)
                begin
                    bse = (rn == 4'hf) ? {pc[31:2], 2'b00} : src;
                    res = (op5 == P_ADDW) ? bse + {20'd0, imm12} : bse - {20'd0, imm12};
                    st = ST_EXEC; wr = 1'b1;
                end
                else if (op5 == P_MOVW || op5 == P_MOVT)
                begin
                    imm16 = {rn, imm12};
                    res = (op5 == P_MOVW) ? {16'd0, imm16} : {imm16, regs[rd][15:0]};
                    st = ST_EXEC; wr = 1'b1;
                end
                else if (op5 >= P_SSAT && op5 <= P_UBFX && !op5[0])
                begin
                    if (i || w[5])
                        st = ST_UNPRED;
                    else if (op5 inside {P_SSAT, P_SSATA, P_USAT, P_USATA})
                    begin
                        asr = op5[1];
                        if (asr && lsb == 5'd0)
                            st = ST_UNPRED;
                        else
                        begin
                            sh = asr ? $unsigned($signed(src) >>> lsb) : src << lsb;
                            x = longint'($signed(sh));
                            if (op5 < P_USAT)
                            begin
                                hi = (longint'(1) << low5) - 1;
                                lo = -(longint'(1) << low5);
                            end
                            else
                            begin
                                hi = (longint'(1) << low5) - 1;
                                lo = 0;
                            end
                            if (x > hi) begin x = hi; qflag = 1'b1; end
                            else if (x < lo) begin x = lo; qflag = 1'b1; end
                            res = x[31:0];
                            st = ST_EXEC; wr = 1'b1;
                        end
                    end
                    else if (op5 == P_BFI)
                    begin
                        if (low5 < lsb)
                            st = ST_UNPRED;
                        else
                        begin
                            m = mask_upto(low5) & ~(mask_upto(lsb) >> 1);
                            ins = (rn == 4'hf) ? '0 : (src << lsb);
                            res = (regs[rd] & ~m) | (ins & m);
                            st = ST_EXEC; wr = 1'b1;
                        end
                    end
                    else if (op5 == P_SBFX || op5 == P_UBFX)
                    begin
                        if ({1'b0, lsb} + {1'b0, low5} > 6'd31)
                            st = ST_UNPRED;
                        else
                        begin
                            v = (src >> lsb) & mask_upto(low5);
                            if (op5 == P_SBFX && v[low5])
                                v = v | ~mask_upto(low5);
                            res = v;
                            st = ST_EXEC; wr = 1'b1;
                        end
                    end
                end
            end
        end
        r = '0;
        if (st == ST_EXEC)
        begin
            r.dest_reg = rd;
            r.result_value = res;
            r.reg_write = wr;
            r.flags_write = fw;
            if (wr)
                regs[rd] = res;
        end
        r.flag_n = nzcv[3];
        r.flag_z = nzcv[2];
        r.flag_c = nzcv[1];
        r.flag_v = nzcv[0];
        r.flag_q = qflag;
        r.status = st;
        return r;
    endfunction

    function automatic result_t unpack_result(input logic [47:0] d);
        result_t r;
        r.reg_write    = d[0];
        r.dest_reg     = d[4:1];
        r.result_value = d[36:5];
        r.flags_write  = d[37];
        r.flag_n       = d[38];
        r.flag_z       = d[39];
        r.flag_c       = d[40];
        r.flag_v       = d[41];
        r.flag_q       = d[42];
        r.status       = d[44:43];
        return r;
    endfunction

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 25);
    endfunction

    // input handshake as seen at the last rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || in_taken)
        begin
            if (pending_items.size() > 0 && !hold_send && !idle_now())
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_items.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= !idle_now();
    end

    // predictor runs on every accepted item
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_results.push_back(execute_instr(s_axis_tdata[31:0], s_axis_tdata[63:32]));
    end

    // monitor
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_result(m_axis_tdata);
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] modimm(input logic [3:0] op, input logic s,
                                           input logic [3:0] rn, input logic [3:0] rd,
                                           input logic [11:0] imm);
        return {5'b11110, imm[11], 1'b0, op, s, rn, 1'b0, imm[10:8], rd, imm[7:0]};
    endfunction

    function automatic logic [31:0] plainimm(input logic [4:0] op5, input logic [3:0] rn,
                                             input logic [3:0] rd, input logic [11:0] imm);
        return {5'b11110, imm[11], 1'b1, op5, rn, 1'b0, imm[10:8], rd, imm[7:0]};
    endfunction

    function automatic logic [3:0] pick_mod_op();
        logic [3:0] ops [10];
        ops = '{OP_AND, OP_BIC, OP_ORR, OP_ORN, OP_EOR, OP_ADD, OP_ADC, OP_SBC, OP_SUB, OP_RSB};
        return ops[$urandom_range(9)];
    endfunction

    function automatic logic [4:0] pick_plain_op();
        logic [4:0] ops [11];
        ops = '{P_ADDW, P_SUBW, P_MOVW, P_MOVT, P_SSAT, P_SSATA, P_SBFX, P_BFI,
                P_USAT, P_USATA, P_UBFX};
        return ops[$urandom_range(10)];
    endfunction

    task automatic add_item(input logic [31:0] w, input logic [31:0] pc);
        pending_items.push_back({pc, w});
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    endtask

    initial
    begin
        logic [31:0] w, pc;
        logic [11:0] imm;
        int          k;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        cycles = 0;
        hold_send = 0;
        quiet = 0;
        foreach (regs[j])
            regs[j] = '0;
        nzcv = '0;
        qflag = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, compare forms, saturation, bad encodings
        add_item(plainimm(P_MOVW, 4'hf, 4'd1, 12'hfff), 32'h0);
        add_item(plainimm(P_MOVT, 4'hf, 4'd1, 12'hfff), 32'h0);
        add_item(modimm(OP_ADD, 1'b1, 4'd1, 4'd2, 12'h001), 32'h0);
        add_item(modimm(OP_SUB, 1'b1, 4'd0, 4'hf, 12'h000), 32'h0);
        add_item(modimm(OP_AND, 1'b1, 4'd1, 4'hf, 12'hfff), 32'h0);
        add_item(modimm(OP_EOR, 1'b1, 4'd1, 4'hf, 12'h4ff), 32'h0);
        add_item(modimm(OP_ADD, 1'b1, 4'd1, 4'hf, 12'h3ff), 32'h0);
        add_item(modimm(OP_ORR, 1'b1, 4'hf, 4'd3, 12'h17f), 32'h0);
        add_item(modimm(OP_ORN, 1'b0, 4'hf, 4'd4, 12'h2a5), 32'h0);
        add_item(modimm(OP_ADC, 1'b1, 4'd3, 4'd5, 12'h800), 32'h0);
        add_item(modimm(OP_SBC, 1'b1, 4'd4, 4'd6, 12'h0ff), 32'h0);
        add_item(modimm(OP_RSB, 1'b1, 4'd1, 4'd7, 12'h000), 32'h0);
        add_item(modimm(OP_BIC, 1'b1, 4'd1, 4'd8, 12'hc00), 32'h0);
        add_item(modimm(OP_ADD, 1'b0, 4'd1, 4'd8, 12'h100), 32'h0);
        add_item(modimm(4'd5, 1'b0, 4'd1, 4'd8, 12'h001), 32'h0);
        add_item(plainimm(P_ADDW, 4'hf, 4'd9, 12'hfff), 32'hffff_ffff);
        add_item(plainimm(P_SUBW, 4'hf, 4'd9, 12'h001), 32'h0000_0002);
        add_item(plainimm(P_SSAT, 4'd1, 4'd10, 12'h000), 32'h0);
        add_item(plainimm(P_USAT, 4'd1, 4'd10, 12'h01f), 32'h0);
        add_item(plainimm(P_SSATA, 4'd1, 4'd10, 12'h000), 32'h0);
        add_item(plainimm(P_BFI, 4'd1, 4'd11, 12'h7df), 32'h0);
        add_item(plainimm(P_BFI, 4'hf, 4'd11, 12'h1c4), 32'h0);
        add_item(plainimm(P_SBFX, 4'd1, 4'd12, 12'h01f), 32'h0);
        add_item(plainimm(P_UBFX, 4'd1, 4'd12, 12'h7c1), 32'h0);
        add_item(plainimm(P_UBFX, 4'd1, 4'd12, 12'h020), 32'h0);
        add_item(32'hf000_8000, 32'h0);
        add_item(32'he000_0000, 32'h0);
        add_item(plainimm(5'd21, 4'd1, 4'd12, 12'h020), 32'h0);

        // once everything is sent, the sender holds off until it has all come back
        wait (pending_items.size() == 0);
        hold_send = 1;
        drain();
        hold_send = 0;

        for (k = 0; k < 1900; k++)
        begin
            quiet = (k >= 600 && k < 900);
            imm = 12'($urandom);
            pc = $urandom;
            case ($urandom_range(9))
                0, 1, 2, 3:
                    w = modimm(pick_mod_op(), 1'($urandom), 4'($urandom), 4'($urandom), imm);
                4, 5, 6, 7:
                begin
                    w = plainimm(pick_plain_op(), 4'($urandom), 4'($urandom), imm);
                    if ($urandom_range(3) != 0)
                        w[5] = 1'b0;
                    if ($urandom_range(3) != 0 && w[24:23] != 2'b00)
                        w[26] = 1'b0;
                end
                default:
                    w = $urandom;
            endcase
            add_item(w, pc);
            if (k % 64 == 63)
                wait (pending_items.size() < 16);
        end
        quiet = 0;
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
sv/t2dp_pkg.sv
sv/t2dp_regfile.sv
sv/t2dp_alu.sv
sv/thumb2_imm_data_processing_unit.sv
sv/t2dp_checker.sv
tb/sv/tb_thumb2_imm_data_processing_unit.sv
